### rtl/dau_pkg.sv
`default_nettype none
package dau_pkg;

   localparam int CRD_W       = 16;
   localparam int TOR_W       = 16;
   localparam int MAG_W       = 64;
   localparam int VEC_W       = 30;
   localparam int ISQ_STEPS   = 16;
   localparam int ISQ_PER     = 2;
   localparam int ISQ_STAGES  = ISQ_STEPS / ISQ_PER;
   localparam int NORM_STEPS  = 6;
   localparam int CORDIC_STEPS = 30;
   localparam int CX_W        = 33;
   localparam int CZ_W        = 34;

   localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10680350, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
      30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
      30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
      30'd20, 30'd10, 30'd5, 30'd3, 30'd1
   };

   typedef struct packed {
      logic             valid;
      logic             xneg;
      logic             tneg;
      logic [MAG_W-1:0] xm;
      logic [MAG_W-1:0] ym;
   } mag_type;

   typedef struct packed {
      logic             valid;
      logic             xneg;
      logic             yneg;
      logic             zero;
      logic [VEC_W-1:0] x;
      logic [VEC_W-1:0] y;
   } vec_type;

   typedef struct packed {
      logic                   valid;
      logic signed [CZ_W-1:0] theta;
   } ang_type;

endpackage
`default_nettype wire

### rtl/dau_isqrt.sv
`default_nettype none
module dau_isqrt (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] v,
   output logic      [15:0] root
);
   import dau_pkg::*;

   logic [31:0] rem_ff [ISQ_STAGES];
   logic [32:0] res_ff [ISQ_STAGES];
   logic [31:0] rem_src [ISQ_STAGES];
   logic [32:0] res_src [ISQ_STAGES];
   logic [31:0] rem_in [ISQ_STAGES];
   logic [32:0] res_in [ISQ_STAGES];

   for (genvar g = 0; g < ISQ_STAGES; g++) begin : g_st
      if (g == 0) begin : g_first
         assign rem_src[g] = v;
         assign res_src[g] = '0;
      end else begin : g_next
         assign rem_src[g] = rem_ff[g-1];
         assign res_src[g] = res_ff[g-1];
      end

      always_comb begin
         logic [31:0] r;
         logic [32:0] q;
         logic [32:0] bitv;
         logic [32:0] trial;
         r = rem_src[g];
         q = res_src[g];
         for (int n = 0; n < ISQ_PER; n++) begin
            bitv  = 33'(1) << (30 - 2 * (g * ISQ_PER + n));
            trial = q + bitv;
            if ({1'b0, r} >= trial) begin
               r = r - trial[31:0];
               q = (q >> 1) + bitv;
            end else begin
               q = q >> 1;
            end
         end
         rem_in[g] = r;
         res_in[g] = q;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in[g];
            res_ff[g] <= res_in[g];
         end
      end
   end

   assign root = res_ff[ISQ_STAGES-1][15:0];

endmodule
`default_nettype wire

### rtl/dau_front.sv
`default_nettype none
module dau_front #(
   parameter int COORD_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [15:0] a_x,
   input  wire logic [15:0] a_y,
   input  wire logic [15:0] a_z,
   input  wire logic [15:0] b_x,
   input  wire logic [15:0] b_y,
   input  wire logic [15:0] b_z,
   input  wire logic [15:0] c_x,
   input  wire logic [15:0] c_y,
   input  wire logic [15:0] c_z,
   output dau_pkg::mag_type mag
);
   import dau_pkg::*;

   localparam int CW  = (COORD_BITS < CRD_W) ? COORD_BITS : CRD_W;
   localparam int SHL = CRD_W - CW;
   localparam int PRE_N = 6;
   localparam int VLD_N = 10;

   typedef struct packed {
      logic        xneg;
      logic        tneg;
      logic [63:0] xm;
      logic [47:0] tm;
   } pre_type;

   function automatic logic signed [15:0] sx(input logic [15:0] f);
      logic [15:0] t;
      begin
         t  = f << SHL;
         sx = $signed(t) >>> SHL;
      end
   endfunction

   logic signed [15:0] av [3];
   logic signed [15:0] bv [3];
   logic signed [15:0] cv [3];

   logic               vld_ff [VLD_N];
   logic signed [15:0] a_ff  [3];
   logic signed [31:0] pr_ff [12];
   logic signed [31:0] pr_in [12];
   logic        [31:0] sq_ff [3];
   logic        [31:0] sq_in [3];
   logic signed [32:0] p_ff  [3];
   logic signed [32:0] q_ff  [3];
   logic signed [15:0] a2_ff [3];
   logic        [31:0] bb_ff;
   logic signed [65:0] pq_ff [3];
   logic signed [48:0] aq_ff [3];
   logic signed [67:0] x_ff;
   logic signed [50:0] t_ff;
   logic signed [67:0] xabs;
   logic signed [50:0] tabs;
   pre_type            pre_ff [PRE_N];
   pre_type            pre_in;
   logic        [15:0] len;
   mag_type            mag_ff;
   mag_type            mag_in;

   assign av[0] = sx(a_x);
   assign av[1] = sx(a_y);
   assign av[2] = sx(a_z);
   assign bv[0] = sx(b_x);
   assign bv[1] = sx(b_y);
   assign bv[2] = sx(b_z);
   assign cv[0] = sx(c_x);
   assign cv[1] = sx(c_y);
   assign cv[2] = sx(c_z);

   always_comb begin
      pr_in[0]  = 32'(av[1]) * 32'(bv[2]);
      pr_in[1]  = 32'(av[2]) * 32'(bv[1]);
      pr_in[2]  = 32'(av[2]) * 32'(bv[0]);
      pr_in[3]  = 32'(av[0]) * 32'(bv[2]);
      pr_in[4]  = 32'(av[0]) * 32'(bv[1]);
      pr_in[5]  = 32'(av[1]) * 32'(bv[0]);
      pr_in[6]  = 32'(bv[1]) * 32'(cv[2]);
      pr_in[7]  = 32'(bv[2]) * 32'(cv[1]);
      pr_in[8]  = 32'(bv[2]) * 32'(cv[0]);
      pr_in[9]  = 32'(bv[0]) * 32'(cv[2]);
      pr_in[10] = 32'(bv[0]) * 32'(cv[1]);
      pr_in[11] = 32'(bv[1]) * 32'(cv[0]);
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = unsigned'(32'(bv[i]) * 32'(bv[i]));
      end
   end

   always_comb begin
      xabs        = x_ff[67] ? -x_ff : x_ff;
      tabs        = t_ff[50] ? -t_ff : t_ff;
      pre_in.xneg = x_ff[67];
      pre_in.tneg = t_ff[50];
      pre_in.xm   = xabs[63:0];
      pre_in.tm   = tabs[47:0];
   end

   dau_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .v     (bb_ff),
      .root  (len)
   );

   always_comb begin
      mag_in.valid = vld_ff[VLD_N-1];
      mag_in.xneg  = pre_ff[PRE_N-1].xneg;
      mag_in.tneg  = pre_ff[PRE_N-1].tneg;
      mag_in.xm    = pre_ff[PRE_N-1].xm;
      mag_in.ym    = 64'(pre_ff[PRE_N-1].tm) * 64'(len);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VLD_N; i++) begin
            vld_ff[i] <= 1'b0;
         end
         mag_ff.valid <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < VLD_N; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         mag_ff <= mag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff <= pr_in;
         sq_ff <= sq_in;
         a_ff  <= av;
         for (int i = 0; i < 3; i++) begin
            p_ff[i]  <= 33'(pr_ff[2*i]) - 33'(pr_ff[2*i+1]);
            q_ff[i]  <= 33'(pr_ff[2*i+6]) - 33'(pr_ff[2*i+7]);
            a2_ff[i] <= a_ff[i];
            pq_ff[i] <= 66'(p_ff[i]) * 66'(q_ff[i]);
            aq_ff[i] <= 49'(a2_ff[i]) * 49'(q_ff[i]);
         end
         bb_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         x_ff  <= 68'(pq_ff[0]) + 68'(pq_ff[1]) + 68'(pq_ff[2]);
         t_ff  <= 51'(aq_ff[0]) + 51'(aq_ff[1]) + 51'(aq_ff[2]);
         pre_ff[0] <= pre_in;
         for (int i = 1; i < PRE_N; i++) begin
            pre_ff[i] <= pre_ff[i-1];
         end
      end
   end

   assign mag = mag_ff;

endmodule
`default_nettype wire

### rtl/dau_norm.sv
`default_nettype none
module dau_norm (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire dau_pkg::mag_type mag,
   output dau_pkg::vec_type      vec
);
   import dau_pkg::*;

   typedef struct packed {
      logic             valid;
      logic             xneg;
      logic             yneg;
      logic             zero;
      logic [MAG_W-1:0] x;
      logic [MAG_W-1:0] y;
   } nrm_type;

   nrm_type st_src [NORM_STEPS];
   nrm_type st_in  [NORM_STEPS];
   nrm_type st_ff  [NORM_STEPS];

   for (genvar g = 0; g < NORM_STEPS; g++) begin : g_st
      localparam int K   = 32 >> g;
      localparam int THR = VEC_W - 1 + K;

      if (g == 0) begin : g_first
         always_comb begin
            st_src[g].valid = mag.valid;
            st_src[g].xneg  = mag.xneg;
            st_src[g].yneg  = mag.tneg && (mag.ym != '0);
            st_src[g].zero  = (mag.xm == '0) && (mag.ym == '0);
            st_src[g].x     = mag.xm;
            st_src[g].y     = mag.ym;
         end
      end else begin : g_next
         assign st_src[g] = st_ff[g-1];
      end

      always_comb begin
         st_in[g] = st_src[g];
         if (((st_src[g].x >> THR) != '0) || ((st_src[g].y >> THR) != '0)) begin
            st_in[g].x = st_src[g].x >> K;
            st_in[g].y = st_src[g].y >> K;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[g].valid <= 1'b0;
         end else if (en) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   always_comb begin
      vec.valid = st_ff[NORM_STEPS-1].valid;
      vec.xneg  = st_ff[NORM_STEPS-1].xneg;
      vec.yneg  = st_ff[NORM_STEPS-1].yneg;
      vec.zero  = st_ff[NORM_STEPS-1].zero;
      vec.x     = st_ff[NORM_STEPS-1].x[VEC_W-1:0];
      vec.y     = st_ff[NORM_STEPS-1].y[VEC_W-1:0];
   end

endmodule
`default_nettype wire

### rtl/dau_cordic.sv
`default_nettype none
module dau_cordic (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire dau_pkg::vec_type vec,
   output dau_pkg::ang_type      ang
);
   import dau_pkg::*;

   localparam logic signed [CZ_W-1:0] Z_HALF = CZ_W'(1) << 30;
   localparam logic signed [CZ_W-1:0] Z_PI   = CZ_W'(1) << 31;

   typedef struct packed {
      logic                   valid;
      logic                   xneg;
      logic                   yneg;
      logic                   zero;
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
   } cst_type;

   cst_type st_src [CORDIC_STEPS];
   cst_type st_in  [CORDIC_STEPS];
   cst_type st_ff  [CORDIC_STEPS];
   ang_type ang_ff;
   ang_type ang_in;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_st
      if (g == 0) begin : g_first
         always_comb begin
            st_src[g].valid = vec.valid;
            st_src[g].xneg  = vec.xneg;
            st_src[g].yneg  = vec.yneg;
            st_src[g].zero  = vec.zero;
            st_src[g].x     = CX_W'(vec.x);
            st_src[g].y     = CX_W'(vec.y);
            st_src[g].z     = '0;
         end
      end else begin : g_next
         assign st_src[g] = st_ff[g-1];
      end

      always_comb begin
         logic signed [CX_W-1:0] xs;
         logic signed [CX_W-1:0] ys;
         logic signed [CX_W-1:0] dx;
         logic signed [CX_W-1:0] dy;
         logic signed [CZ_W-1:0] da;
         xs = st_src[g].x;
         ys = st_src[g].y;
         dx = ys >>> g;
         dy = xs >>> g;
         da = $signed(CZ_W'(ATAN_TAB[g]));
         st_in[g] = st_src[g];
         if (!ys[CX_W-1] && (ys != '0)) begin
            st_in[g].x = xs + dx;
            st_in[g].y = ys - dy;
            st_in[g].z = st_src[g].z + da;
         end else if (ys[CX_W-1]) begin
            st_in[g].x = xs - dx;
            st_in[g].y = ys + dy;
            st_in[g].z = st_src[g].z - da;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[g].valid <= 1'b0;
         end else if (en) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   always_comb begin
      logic signed [CZ_W-1:0] zc;
      logic signed [CZ_W-1:0] th;
      zc = st_ff[CORDIC_STEPS-1].z;
      if (zc[CZ_W-1]) begin
         zc = '0;
      end else if (zc > Z_HALF) begin
         zc = Z_HALF;
      end
      th = st_ff[CORDIC_STEPS-1].xneg ? (Z_PI - zc) : zc;
      if (st_ff[CORDIC_STEPS-1].yneg) begin
         th = -th;
      end
      if (st_ff[CORDIC_STEPS-1].zero) begin
         th = '0;
      end
      ang_in.valid = st_ff[CORDIC_STEPS-1].valid;
      ang_in.theta = th;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff.valid <= 1'b0;
      end else if (en) begin
         ang_ff <= ang_in;
      end
   end

   assign ang = ang_ff;

endmodule
`default_nettype wire

### rtl/dihedral_angle_unit.sv
// Throughput: one beat per cycle while the output skid is empty (a full skid stalls
// every stage); the 30-stage CORDIC, the 8-stage square root and the 6-stage shift
// normaliser are fully pipelined, with a one-entry skid at the output.
// Reset (synchronous, active high) clears every stage valid bit and the output and
// skid valid flags; no result is pending afterwards.
`default_nettype none
module dihedral_angle_unit #(
   parameter int COORD_BITS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_a_x,
   input  wire logic signed [15:0] req_a_y,
   input  wire logic signed [15:0] req_a_z,
   input  wire logic signed [15:0] req_b_x,
   input  wire logic signed [15:0] req_b_y,
   input  wire logic signed [15:0] req_b_z,
   input  wire logic signed [15:0] req_c_x,
   input  wire logic signed [15:0] req_c_y,
   input  wire logic signed [15:0] req_c_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_torsion
);
   import dau_pkg::*;

   localparam int SH = 32 - ANGLE_BITS;
   localparam logic signed [CZ_W-1:0] RND = (SH > 0) ? (CZ_W'(1) << (SH - 1)) : '0;
   localparam logic [TOR_W-1:0] MASK =
      (ANGLE_BITS >= TOR_W) ? '1 : TOR_W'((64'(1) << ANGLE_BITS) - 64'(1));

   logic                   en;
   mag_type                mag;
   vec_type                vec;
   ang_type                ang;
   logic signed [CZ_W-1:0] rsum;
   logic signed [CZ_W-1:0] rshf;
   logic [TOR_W-1:0]       tor;
   logic                   out_vld_ff;
   logic                   out_vld_in;
   logic [TOR_W-1:0]       out_ff;
   logic [TOR_W-1:0]       out_in;
   logic                   skid_vld_ff;
   logic                   skid_vld_in;
   logic [TOR_W-1:0]       skid_ff;
   logic [TOR_W-1:0]       skid_in;

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   dau_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .a_x      (req_a_x),
      .a_y      (req_a_y),
      .a_z      (req_a_z),
      .b_x      (req_b_x),
      .b_y      (req_b_y),
      .b_z      (req_b_z),
      .c_x      (req_c_x),
      .c_y      (req_c_y),
      .c_z      (req_c_z),
      .mag      (mag)
   );

   dau_norm u_norm (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .mag   (mag),
      .vec   (vec)
   );

   dau_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .vec   (vec),
      .ang   (ang)
   );

   always_comb begin
      rsum = ang.theta + RND;
      rshf = rsum >>> SH;
      tor  = rshf[TOR_W-1:0] & MASK;
   end

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (rsp_ready) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!out_vld_ff || rsp_ready) begin
         out_vld_in = ang.valid;
         out_in     = tor;
      end else if (ang.valid) begin
         skid_vld_in = 1'b1;
         skid_in     = tor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_torsion = $signed(out_ff);

endmodule
`default_nettype wire
